// ----- src/sma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_pkg
// Shared widths, instruction and status codes, and the execute result type
// of the stack machine execution unit.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    // instruction codes
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_ADD  = 2'd2;
    localparam logic [1:0] KIND_SUB  = 2'd3;

    // status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_POP_EMPTY = 3'd1;
    localparam logic [2:0] STAT_ADD_SHORT = 3'd2;
    localparam logic [2:0] STAT_SUB_SHORT = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;
    localparam logic [2:0] STAT_HALTED    = 3'd5;

    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] word_t;

    // outcome of one instruction, applied by the sequencer
    typedef struct packed {
        logic [2:0] status;
        word_t      tos;
        count_t     count;
        logic       wr_en;
        addr_t      wr_addr;
        word_t      wr_data;
        logic       halt_set;
    } exec_res_t;

endpackage

// ----- src/sma_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_cmd_if / sma_rsp_if
// Valid/ready channels for instructions in and results out.
// ----------------------------------------------------------------------------
interface sma_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic signed [sma_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface sma_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic signed [sma_pkg::DATA_W-1:0] top_value;
    logic [sma_pkg::CNT_W-1:0]   entry_count;

    modport source (output valid, output status, output top_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input top_value, input entry_count,
                    output ready);
endinterface

// ----- src/sma_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_exec
// Decodes one instruction against the current stack and computes the new
// top, count, memory write and status through the shared add/sub unit.
// ----------------------------------------------------------------------------
module sma_exec (
    input  logic [1:0]         kind,
    input  sma_pkg::word_t     push_value,
    input  sma_pkg::count_t    count,
    input  sma_pkg::word_t     tos,
    input  sma_pkg::word_t     second,
    input  logic               halted,
    output sma_pkg::exec_res_t res
);
    import sma_pkg::*;

    word_t  alu_out;
    count_t count_m2;

    // shared add/sub unit: second op top
    assign alu_out  = (kind == KIND_SUB) ? (second - tos) : (second + tos);
    assign count_m2 = count - count_t'(2);

    // instruction decode
    always_comb
    begin
        res          = '0;
        res.status   = STAT_OK;
        res.tos      = tos;
        res.count    = count;
        res.wr_en    = 1'b0;
        res.wr_addr  = count[ADDR_W-1:0];
        res.wr_data  = push_value;
        if (halted)
        begin
            res.status = STAT_HALTED;
        end
        else
        begin
            unique case (kind) inside
                KIND_PUSH:
                begin
                    if (count >= count_t'(STACK_DEPTH))
                    begin
                        res.status = STAT_FULL;
                    end
                    else
                    begin
                        res.wr_en = 1'b1;
                        res.tos   = push_value;
                        res.count = count + count_t'(1);
                    end
                end
                KIND_POP:
                begin
                    if (count == '0)
                    begin
                        res.status = STAT_POP_EMPTY;
                    end
                    else
                    begin
                        res.count = count - count_t'(1);
                        res.tos   = (count == count_t'(1)) ? '0 : second;
                    end
                end
                KIND_ADD, KIND_SUB:
                begin
                    if (count < count_t'(2))
                    begin
                        res.status = (kind == KIND_ADD) ? STAT_ADD_SHORT : STAT_SUB_SHORT;
                    end
                    else
                    begin
                        res.wr_en   = 1'b1;
                        res.wr_addr = count_m2[ADDR_W-1:0];
                        res.wr_data = alu_out;
                        res.tos     = alu_out;
                        res.count   = count - count_t'(1);
                    end
                end
                default:
                begin
                    res.status = STAT_OK;
                end
            endcase
        end
        res.halt_set = (res.status != STAT_OK) && (res.status != STAT_HALTED);
    end

endmodule

// ----- src/stack_machine_alu.sv -----
`timescale 1ns / 1ps
// A command transfer enters execute, which registers the result; the next
// instruction waits for idle and a free result register. The second-from-top
// entry is registered from the single stack memory read port at the command
// transfer; the top entry is kept in a register beside the memory.
// Reset clears the entry count, top register, halt flag and handshakes;
// the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
// stack_machine_alu
// Execution unit of a stack interpreter: push, pop, add and subtract on
// 32-bit two's complement entries with a sticky halt on error.
// ----------------------------------------------------------------------------
module stack_machine_alu (
    input  logic      clk,
    input  logic      rst_n,
    sma_cmd_if.sink   cmd,
    sma_rsp_if.source rsp
);
    import sma_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic       state_reg;
    logic       state_next;
    count_t     count_reg;
    word_t      tos_reg;
    logic       halted_reg;
    logic       rsp_valid_reg;
    logic [2:0] status_reg;
    logic [1:0] kind_reg;
    word_t      value_reg;
    word_t      rd_data_reg;
    addr_t      rd_addr;
    count_t     rd_cnt;
    logic       cmd_xfer;
    logic       rsp_xfer;
    exec_res_t  res;

    word_t stack_mem [STACK_DEPTH];

    // handshakes
    assign cmd.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign rsp_xfer  = rsp_valid_reg && rsp.ready;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.top_value   = tos_reg;
    assign rsp.entry_count = count_reg;

    // stack memory: second-from-top read every cycle, write on execute
    assign rd_cnt  = count_reg - count_t'(2);
    assign rd_addr = rd_cnt[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        rd_data_reg <= stack_mem[rd_addr];
        if ((state_reg == S_EXEC) && res.wr_en)
        begin
            stack_mem[res.wr_addr] <= res.wr_data;
        end
    end

    // capture instruction on transfer
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            kind_reg  <= cmd.kind;
            value_reg <= cmd.push_value;
        end
    end

    sma_exec u_exec (
        .kind       (kind_reg),
        .push_value (value_reg),
        .count      (count_reg),
        .tos        (tos_reg),
        .second     (rd_data_reg),
        .halted     (halted_reg),
        .res        (res)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // stack state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tos_reg       <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                count_reg     <= res.count;
                tos_reg       <= res.tos;
                halted_reg    <= halted_reg | res.halt_set;
                status_reg    <= res.status;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_xfer)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // count stays within the stack depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(STACK_DEPTH))
        else $error("entry count above stack depth");

    // halt flag is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    // halted status only reported once halted
    a_halted_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == STAT_HALTED)) |-> halted_reg)
        else $error("halted status without halt flag");

    // a command transfer is followed by execute and then a valid result
    a_cmd_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> (state_reg == S_EXEC) ##1 rsp_valid_reg)
        else $error("result not produced after command");

    // an empty stack reports a zero top
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (tos_reg == '0))
        else $error("nonzero top on empty stack");
`endif

endmodule

// ----- tb/stack_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_result_checker
// Watches the instruction and result channels of the stack machine execution
// unit. It keeps its own copy of the stack and the halt flag, works out the
// result of each instruction transfer, and checks each result transfer
// against the oldest result still owed.
// ----------------------------------------------------------------------------
module stack_result_checker (
    input  logic      clk,
    input  logic      rst_n,
    sma_cmd_if        cmd,
    sma_rsp_if        rsp,
    output int        mismatches,
    output int        outstanding
);
    import sma_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        word_t      top_value;
        count_t     entry_count;
    } alu_result_t;

    // shadow stack state
    word_t       shadow_stack [STACK_DEPTH];
    int unsigned shadow_fill;
    bit          shadow_halted;

    alu_result_t owed_results [$];

    // apply one instruction to the shadow stack and return its result
    function automatic alu_result_t execute_instr(input logic [1:0] kind, input word_t value);
        alu_result_t r;
        word_t       tos;
        word_t       nos;
        r.status = STAT_OK;
        if (shadow_halted)
        begin
            r.status = STAT_HALTED;
        end
        else
        begin
            case (kind)
                KIND_PUSH:
                begin
                    if (shadow_fill >= STACK_DEPTH)
                        r.status = STAT_FULL;
                    else
                    begin
                        shadow_stack[shadow_fill] = value;
                        shadow_fill++;
                    end
                end
                KIND_POP:
                begin
                    if (shadow_fill == 0)
                        r.status = STAT_POP_EMPTY;
                    else
                        shadow_fill--;
                end
                default:
                begin
                    if (shadow_fill < 2)
                        r.status = (kind == KIND_ADD) ? STAT_ADD_SHORT : STAT_SUB_SHORT;
                    else
                    begin
                        tos = shadow_stack[shadow_fill - 1];
                        nos = shadow_stack[shadow_fill - 2];
                        shadow_stack[shadow_fill - 2] = (kind == KIND_ADD) ? nos + tos
                                                                           : nos - tos;
                        shadow_fill--;
                    end
                end
            endcase
            // any error stops the machine for good
            if (r.status != STAT_OK)
                shadow_halted = 1'b1;
        end
        r.top_value   = (shadow_fill == 0) ? '0 : shadow_stack[shadow_fill - 1];
        r.entry_count = count_t'(shadow_fill);
        return r;
    endfunction

    // predict on instruction transfers, compare on result transfers
    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t want;
        if (!rst_n)
        begin
            shadow_fill   = 0;
            shadow_halted = 1'b0;
            mismatches    = 0;
            owed_results.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                owed_results.push_back(execute_instr(cmd.kind, cmd.push_value));
            if (rsp.valid && rsp.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result transfer: status %0d top %0d count %0d",
                             $time, rsp.status, rsp.top_value, rsp.entry_count);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                    end
                    if (rsp.top_value !== want.top_value)
                    begin
                        mismatches++;
                        $display("%0t: top_value expected %0d actual %0d",
                                 $time, $signed(want.top_value), rsp.top_value);
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        mismatches++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, rsp.entry_count);
                    end
                end
            end
        end
        outstanding = owed_results.size();
    end

endmodule

// ----- tb/stack_machine_alu_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_alu_tb
// Drives instruction sequences into the stack machine execution unit: a short
// directed run over the wrap cases, a long random walk of legal instructions
// that fills the stack to the top, and one final error followed by refused
// instructions. Both channels stall at random; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module stack_machine_alu_tb;
    import sma_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 450;
    localparam int HALTED_ITEMS = 8;
    localparam int IDLE_PCT     = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 100000;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   level;
    int   mismatches;
    int   outstanding;
    bit   steady;

    sma_cmd_if cmd_ch ();
    sma_rsp_if rsp_ch ();

    stack_machine_alu u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    stack_result_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side backpressure
    always @(negedge clk)
        rsp_ch.ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);

    // operand mix with the corner values showing up often
    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // an instruction that shrinks the stack and is legal at this level
    function automatic logic [1:0] shrink_kind();
        if (level < 2)
            return KIND_POP;
        case ($urandom_range(0, 2))
            0:       return KIND_POP;
            1:       return KIND_ADD;
            default: return KIND_SUB;
        endcase
    endfunction

    // one instruction transfer, with random idle cycles ahead of it
    task automatic send_instr(input logic [1:0] kind, input word_t value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      = 1'b1;
        cmd_ch.kind       = kind;
        cmd_ch.push_value = value;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
        // track the fill level for the stimulus only
        case (kind)
            KIND_PUSH: if (level < STACK_DEPTH) level++;
            KIND_POP:  if (level > 0) level--;
            default:   if (level >= 2) level--;
        endcase
    endtask

    // hold off until every result is back
    task automatic wait_for_results();
        cmd_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // legal step of the random walk, drifting toward the goal level
    task automatic walk_step(input int goal);
        int         push_pct;
        logic [1:0] k;
        push_pct = (level < goal) ? 90 : 30;
        if (level == 0)
            k = KIND_PUSH;
        else if (level >= STACK_DEPTH)
            k = shrink_kind();
        else if ($urandom_range(0, 99) < push_pct)
            k = KIND_PUSH;
        else
            k = shrink_kind();
        send_instr(k, rand_word());
    endtask

    initial
    begin
        int         goal;
        logic [1:0] err_kind;

        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.kind       = KIND_PUSH;
        cmd_ch.push_value = '0;
        steady            = 1'b0;
        level             = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: wrap on add and subtract, extremes, pop to empty
        send_instr(KIND_PUSH, 32'h7FFF_FFFF);
        send_instr(KIND_PUSH, 32'h0000_0001);
        send_instr(KIND_ADD,  $urandom());
        send_instr(KIND_PUSH, 32'h0000_0001);
        send_instr(KIND_SUB,  $urandom());
        send_instr(KIND_PUSH, 32'h8000_0000);
        send_instr(KIND_SUB,  $urandom());
        send_instr(KIND_PUSH, 32'hFFFF_FFFF);
        send_instr(KIND_ADD,  $urandom());
        send_instr(KIND_POP,  $urandom());
        send_instr(KIND_PUSH, 32'h0000_0000);
        send_instr(KIND_PUSH, 32'h8000_0000);
        send_instr(KIND_PUSH, 32'h7FFF_FFFF);
        send_instr(KIND_ADD,  $urandom());
        send_instr(KIND_POP,  $urandom());
        send_instr(KIND_POP,  $urandom());
        send_instr(KIND_PUSH, 32'hAAAA_AAAA);
        send_instr(KIND_PUSH, 32'h5555_5555);
        send_instr(KIND_SUB,  $urandom());
        send_instr(KIND_POP,  $urandom());
        wait_for_results();

        // random walk: climb to a full stack first, then wander
        goal = STACK_DEPTH;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 120 && i < 240);
            if (i == RANDOM_ITEMS / 2)
                wait_for_results();
            if (level == goal)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: goal = $urandom_range(0, 6);
                    5, 6, 7:       goal = $urandom_range(0, STACK_DEPTH);
                    default:       goal = STACK_DEPTH;
                endcase
            end
            walk_step(goal);
        end
        steady = 1'b0;

        // one error to finish with, picked by the seed
        err_kind = 2'($urandom_range(0, 3));
        case (err_kind)
            KIND_PUSH:
            begin
                while (level < STACK_DEPTH)
                    send_instr(KIND_PUSH, rand_word());
            end
            KIND_POP:
            begin
                while (level > 0)
                    send_instr(shrink_kind(), rand_word());
            end
            default:
            begin
                while (level > 1)
                    send_instr(shrink_kind(), rand_word());
            end
        endcase
        send_instr(err_kind, rand_word());

        // everything after the error is refused
        for (int i = 0; i < HALTED_ITEMS; i++)
            send_instr(2'($urandom_range(0, 3)), rand_word());

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
